[design/i2c_master_transfer_sequencer_core_macros.svh]
// assertion helper macros shared by the sequencer core modules
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_MACROS_SVH

// expression holds at every clock edge out of reset
`define I2CSEQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define I2CSEQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define I2CSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/i2cseq_pkg.sv]
// shared types, constants and helpers for the i2c master transfer sequencer
`default_nettype none

package i2cseq_pkg;

  // transmit buffer geometry
  localparam int BUFFER_BYTES = 16;
  localparam int BUF_AW       = $clog2(BUFFER_BYTES);
  localparam int STORE_DEPTH  = 2 * BUFFER_BYTES;
  localparam int STORE_AW     = BUF_AW + 1;
  localparam int LEN_W        = 5;

  // upper bound on phase steps chained by one item
  localparam int CHAIN_STEPS  = 6;

  // queue between front and back, depth is a power of two
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEN_BIT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LENGTH  = 3'd4;

  // input operation codes
  localparam logic [1:0] OP_EVENT    = 2'd0;
  localparam logic [1:0] OP_LOAD     = 2'd1;
  localparam logic [1:0] OP_BEGIN    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // transfer modes
  localparam logic [1:0] MODE_WRITE      = 2'd0;
  localparam logic [1:0] MODE_READ       = 2'd1;
  localparam logic [1:0] MODE_WRITE_READ = 2'd2;
  localparam logic [1:0] MODE_WRITE_TWO  = 2'd3;

  // bus command bits
  localparam logic [3:0] CMD_START = 4'b0001;
  localparam logic [3:0] CMD_STOP  = 4'b0010;
  localparam logic [3:0] CMD_ACK   = 4'b0100;
  localparam logic [3:0] CMD_NACK  = 4'b1000;

  // flag clear bits
  localparam logic [2:0] CLR_ACK  = 3'b001;
  localparam logic [2:0] CLR_NACK = 3'b010;
  localparam logic [2:0] CLR_STOP = 3'b100;

  // address byte constants
  localparam logic [7:0] ADDR10_PREFIX  = 8'hf0;
  localparam logic [7:0] ADDR10_HI_MASK = 8'h06;
  localparam logic [7:0] ADDR7_MASK     = 8'hfe;
  localparam logic [7:0] BYTE_MASK      = 8'hff;

  typedef enum logic [3:0] {
    PH_DONE        = 4'd0,
    PH_START_SEND  = 4'd1,
    PH_ADDR_WAIT   = 4'd2,
    PH_ADDR2_WAIT  = 4'd3,
    PH_RSTART_SEND = 4'd4,
    PH_RADDR_WAIT  = 4'd5,
    PH_DATA_SEND   = 4'd6,
    PH_DATA_WAIT   = 4'd7,
    PH_RX_WAIT     = 4'd8,
    PH_STOP_WAIT   = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_DONE    = 3'd1,
    ST_NACK    = 3'd2,
    ST_ARB     = 3'd3,
    ST_BUSERR  = 3'd4,
    ST_SWFAULT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_BEGIN = 2'd2
  } item_kind_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       flag_ack;
    logic       flag_nack;
    logic       flag_rx_valid;
    logic       flag_stop_sent;
    logic       flag_arb_lost;
    logic       flag_bus_error;
    logic [7:0] received_byte;
    logic       load_buffer;
    logic [3:0] load_offset;
    logic [7:0] load_value;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] command_bits;
    logic [2:0] clear_flags;
    logic       rx_write;
    logic       rx_buffer;
    logic [3:0] rx_offset;
    logic [7:0] rx_data;
    logic       interrupts_off;
  } out_item_t;

  typedef struct packed {
    logic ack;
    logic nack;
    logic rx_valid;
    logic stop_sent;
    logic arb_lost;
    logic bus_error;
  } bus_flags_t;

  // one classified item waiting for the back end
  typedef struct packed {
    item_kind_t  kind;
    bus_flags_t  flags;
    logic [7:0]  received_byte;
    logic        load_buffer;
    logic [3:0]  load_offset;
    logic [7:0]  load_value;
  } queue_entry_t;

  // bus actions gathered over one chain of phase steps
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] cmd;
    logic [2:0] clr;
    logic       rx_write;
    logic       rx_buffer;
    logic [3:0] rx_offset;
  } action_t;

  // byte count of a buffer, saturated, zero past the second buffer
  function automatic logic [LEN_W-1:0] buf_len(input logic [1:0] idx,
                                                input logic [LEN_W-1:0] len0,
                                                input logic [LEN_W-1:0] len1);
    logic [LEN_W-1:0] n;
    case (idx)
      2'd0: n = len0;
      2'd1: n = len1;
      default: n = '0;
    endcase
    if (n > LEN_W'(BUFFER_BYTES)) n = LEN_W'(BUFFER_BYTES);
    return n;
  endfunction

  // first byte of a 10-bit address
  function automatic logic [7:0] addr10_first(input logic [10:0] ta);
    return (8'(ta >> 8) & ADDR10_HI_MASK) | ADDR10_PREFIX;
  endfunction

endpackage

`default_nettype wire

[design/i2cseq_front.sv]
// front end: accepts input items, drops unused operations, classifies the rest
`default_nettype none

module i2cseq_front
  import i2cseq_pkg::*;
(
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire in_item_t     in_data,
  input  wire logic         q_full,
  output logic              q_push,
  output queue_entry_t      q_push_entry
);

  // accept whenever the queue has room
  assign in_ready = !q_full;

  // classify the operation
  always_comb begin
    q_push_entry               = '0;
    q_push_entry.flags.ack       = in_data.flag_ack;
    q_push_entry.flags.nack      = in_data.flag_nack;
    q_push_entry.flags.rx_valid  = in_data.flag_rx_valid;
    q_push_entry.flags.stop_sent = in_data.flag_stop_sent;
    q_push_entry.flags.arb_lost  = in_data.flag_arb_lost;
    q_push_entry.flags.bus_error = in_data.flag_bus_error;
    q_push_entry.received_byte = in_data.received_byte;
    q_push_entry.load_buffer   = in_data.load_buffer;
    q_push_entry.load_offset   = in_data.load_offset;
    q_push_entry.load_value    = in_data.load_value;
    q_push = in_valid && !q_full;
    case (in_data.operation)
      OP_EVENT: q_push_entry.kind = KIND_EVENT;
      OP_LOAD:  q_push_entry.kind = KIND_LOAD;
      OP_BEGIN: q_push_entry.kind = KIND_BEGIN;
      default: begin
        // unused operation is consumed without effect
        q_push_entry.kind = KIND_EVENT;
        q_push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/i2cseq_queue.sv]
// short fifo of classified items between front and back end
`default_nettype none
`include "i2c_master_transfer_sequencer_core_macros.svh"

module i2cseq_queue
  import i2cseq_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire queue_entry_t  push_entry,
  output logic               full,
  output logic               pop_valid,
  input  wire logic          pop,
  output queue_entry_t       pop_entry
);

  queue_entry_t               entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]        wr_ptr_r;
  logic [QUEUE_AW-1:0]        rd_ptr_r;
  logic [QUEUE_CNT_W-1:0]     count_r;

  assign full      = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = entries_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      if (push && !pop) begin
        count_r <= count_r + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QUEUE_CNT_W'(1);
      end
    end
  end

  `I2CSEQ_ASSERT_IMPL(a_q_no_underflow, pop, count_r != '0, "queue popped while empty")
  `I2CSEQ_ASSERT_IMPL(a_q_no_overflow, push && !pop, !full, "queue pushed while full")
  `I2CSEQ_ASSERT_NEXT(a_q_count_up, push && !pop, count_r == $past(count_r) + 2'd1, "queue count did not rise")

endmodule

`default_nettype wire

[design/i2cseq_back.sv]
// back end: configuration, transmit store, phase sequencer and result register
`default_nettype none
`include "i2c_master_transfer_sequencer_core_macros.svh"

module i2cseq_back
  import i2cseq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  q_valid,
  input  wire queue_entry_t          q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  // configuration registers
  logic [10:0]      target_address_r;
  logic [1:0]       transfer_mode_r;
  logic             ten_bit_r;
  logic [LEN_W-1:0] first_length_r;
  logic [LEN_W-1:0] second_length_r;

  // sequencer state
  phase_t           phase_r;
  status_t          outcome_r;
  logic [1:0]       buffer_index_r;
  logic [LEN_W-1:0] byte_offset_r;

  phase_t           phase_nxt;
  status_t          outcome_nxt;
  logic [1:0]       buffer_index_nxt;
  logic [LEN_W-1:0] byte_offset_nxt;

  logic [7:0]       store_r [STORE_DEPTH];

  logic             out_valid_r;
  out_item_t        out_data_r;

  action_t          act;
  out_item_t        res;
  logic             needs_out;
  logic             take;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_address_r <= '0;
      transfer_mode_r  <= MODE_WRITE;
      ten_bit_r        <= 1'b0;
      first_length_r   <= '0;
      second_length_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_ADDRESS: target_address_r <= cfg_wdata;
        CFG_TRANSFER_MODE:  transfer_mode_r  <= cfg_wdata[1:0];
        CFG_TEN_BIT:        ten_bit_r        <= cfg_wdata[0];
        CFG_FIRST_LENGTH:   first_length_r   <= cfg_wdata[LEN_W-1:0];
        CFG_SECOND_LENGTH:  second_length_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pop rule: loads always drain, others need a free result slot
  assign needs_out = (q_entry.kind != KIND_LOAD);
  assign q_pop     = q_valid && (!needs_out || !out_valid_r || out_ready);
  assign take      = q_pop && needs_out;

  // transmit store writes
  always_ff @(posedge clk) begin
    if (q_pop && q_entry.kind == KIND_LOAD &&
        int'(q_entry.load_offset) < BUFFER_BYTES) begin
      store_r[{q_entry.load_buffer, q_entry.load_offset[BUF_AW-1:0]}] <= q_entry.load_value;
    end
  end

  // next state: chain of phase steps triggered by one item
  always_comb begin : chain
    phase_t           ph;
    status_t          oc;
    logic [1:0]       idx;
    logic [LEN_W-1:0] ofs;
    logic [LEN_W-1:0] n;
    bus_flags_t       fl;
    logic             again;
    logic             reading;
    action_t          a;

    ph  = phase_r;
    oc  = outcome_r;
    idx = buffer_index_r;
    ofs = byte_offset_r;
    fl  = q_entry.flags;
    if (q_entry.kind == KIND_BEGIN) begin
      ph  = PH_START_SEND;
      oc  = ST_BUSY;
      idx = '0;
      ofs = '0;
      fl  = '0;
    end
    a       = '0;
    n       = '0;
    again   = 1'b1;
    reading = (transfer_mode_r == MODE_READ) || (transfer_mode_r == MODE_WRITE_READ);

    for (int s = 0; s < CHAIN_STEPS; s++) begin
      if (again) begin
        again = 1'b0;
        if (fl.arb_lost || fl.bus_error) begin
          // faults end the transfer at once
          oc = fl.arb_lost ? ST_ARB : ST_BUSERR;
          ph = PH_DONE;
        end else begin
          case (ph)
            PH_START_SEND: begin
              if (ten_bit_r) begin
                a.tx_byte = addr10_first(target_address_r);
              end else begin
                a.tx_byte = target_address_r[7:0] & ADDR7_MASK;
                if (transfer_mode_r == MODE_READ) a.tx_byte[0] = 1'b1;
              end
              a.tx_valid = 1'b1;
              a.cmd      = a.cmd | CMD_START;
              ph         = PH_ADDR_WAIT;
            end
            PH_ADDR_WAIT, PH_ADDR2_WAIT, PH_RADDR_WAIT, PH_DATA_WAIT: begin
              if (fl.nack) begin
                a.clr = a.clr | CLR_NACK;
                oc    = ST_NACK;
                ph    = PH_STOP_WAIT;
                a.cmd = a.cmd | CMD_STOP;
              end else if (fl.ack) begin
                a.clr = a.clr | CLR_ACK;
                case (ph)
                  PH_ADDR_WAIT: begin
                    if (ten_bit_r) begin
                      ph         = PH_ADDR2_WAIT;
                      a.tx_valid = 1'b1;
                      a.tx_byte  = target_address_r[7:0] & BYTE_MASK;
                    end else if (transfer_mode_r == MODE_READ) begin
                      ph = PH_RX_WAIT;
                      if (buf_len(idx, first_length_r, second_length_r) == LEN_W'(1)) begin
                        a.cmd = a.cmd | CMD_NACK;
                      end
                    end else begin
                      ph    = PH_DATA_SEND;
                      again = 1'b1;
                    end
                  end
                  PH_ADDR2_WAIT: begin
                    ph    = (transfer_mode_r == MODE_READ) ? PH_RSTART_SEND : PH_DATA_SEND;
                    again = 1'b1;
                  end
                  PH_RADDR_WAIT: begin
                    if (reading) begin
                      ph = PH_RX_WAIT;
                    end else begin
                      ph    = PH_DATA_SEND;
                      again = 1'b1;
                    end
                  end
                  default: begin
                    ph    = PH_DATA_SEND;
                    again = 1'b1;
                  end
                endcase
              end
            end
            PH_RSTART_SEND: begin
              a.tx_byte = ten_bit_r ? addr10_first(target_address_r)
                                    : (target_address_r[7:0] & ADDR7_MASK);
              if (reading) a.tx_byte[0] = 1'b1;
              a.tx_valid = 1'b1;
              a.cmd      = a.cmd | CMD_START;
              ph         = PH_RADDR_WAIT;
            end
            PH_DATA_SEND: begin
              n = buf_len(idx, first_length_r, second_length_r);
              if (ofs >= n) begin
                // buffer exhausted, move to the next one
                ofs = '0;
                idx = idx + 2'd1;
                if (transfer_mode_r == MODE_WRITE_READ) begin
                  ph    = PH_RSTART_SEND;
                  again = 1'b1;
                end else if (transfer_mode_r == MODE_WRITE || idx > 2'd1) begin
                  ph    = PH_STOP_WAIT;
                  a.cmd = a.cmd | CMD_STOP;
                end else begin
                  again = 1'b1;
                end
              end else begin
                a.tx_valid = 1'b1;
                a.tx_byte  = store_r[{idx[0], ofs[BUF_AW-1:0]}];
                ofs        = ofs + LEN_W'(1);
                ph         = PH_DATA_WAIT;
              end
            end
            PH_RX_WAIT: begin
              if (fl.rx_valid) begin
                n = buf_len(idx, first_length_r, second_length_r);
                if (ofs < n) begin
                  a.rx_write  = 1'b1;
                  a.rx_buffer = idx[0];
                  a.rx_offset = ofs[BUF_AW-1:0];
                  ofs         = ofs + LEN_W'(1);
                end
                if (ofs >= n) begin
                  if (n == LEN_W'(1)) a.cmd = a.cmd | CMD_NACK;
                  ph    = PH_STOP_WAIT;
                  a.cmd = a.cmd | CMD_STOP;
                end else begin
                  a.cmd = a.cmd | CMD_ACK;
                  if (n > LEN_W'(1) && ofs == n - LEN_W'(1)) a.cmd = a.cmd | CMD_NACK;
                end
              end
            end
            PH_STOP_WAIT: begin
              if (fl.stop_sent) begin
                a.clr = a.clr | CLR_STOP;
                ph    = PH_DONE;
              end
            end
            default: begin
              // event with no transfer running
              oc = ST_SWFAULT;
              ph = PH_DONE;
            end
          endcase
        end
      end
    end

    if (ph == PH_DONE && oc == ST_BUSY) oc = ST_DONE;

    phase_nxt        = ph;
    outcome_nxt      = oc;
    buffer_index_nxt = idx;
    byte_offset_nxt  = ofs;
    act              = a;
  end

  // result formatting
  always_comb begin : result_fmt
    res                = '0;
    res.interrupts_off = (phase_nxt == PH_DONE);
    res.status         = (phase_nxt == PH_DONE) ? outcome_nxt : ST_BUSY;
    res.tx_valid       = act.tx_valid;
    res.tx_byte        = act.tx_valid ? act.tx_byte : '0;
    res.command_bits   = act.cmd;
    res.clear_flags    = act.clr;
    res.rx_write       = act.rx_write;
    res.rx_buffer      = act.rx_write ? act.rx_buffer : 1'b0;
    res.rx_offset      = act.rx_write ? act.rx_offset : '0;
    res.rx_data        = act.rx_write ? q_entry.received_byte : '0;
  end

  // sequencer state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_DONE;
      outcome_r      <= ST_BUSY;
      buffer_index_r <= '0;
      byte_offset_r  <= '0;
    end else if (take) begin
      phase_r        <= phase_nxt;
      outcome_r      <= outcome_nxt;
      buffer_index_r <= buffer_index_nxt;
      byte_offset_r  <= byte_offset_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `I2CSEQ_ASSERT_IMPL(a_irq_off_when_finished, out_valid_r, out_data_r.interrupts_off == (out_data_r.status != ST_BUSY), "interrupts_off disagrees with status")
  `I2CSEQ_ASSERT_NEXT(a_begin_waits_addr, take && q_entry.kind == KIND_BEGIN, phase_r == PH_ADDR_WAIT, "begin did not reach address wait")
  `I2CSEQ_ASSERT_NEXT(a_load_no_result, q_pop && q_entry.kind == KIND_LOAD && !out_valid_r, !out_valid_r, "load produced a result")

endmodule

`default_nettype wire

[design/i2c_master_transfer_sequencer_core.sv]
// top level of the i2c master transfer sequencer
//
//   port group  direction  handshake        payload
//   in_*        input      in_valid/ready   in_item_t (operation, flags, loads)
//   out_*       output     out_valid/ready  out_item_t (status, tx, commands, rx)
//   cfg_*       input      cfg_we           cfg_index, cfg_wdata
//
// one item per cycle sustained while the output is not stalled; a bus event or
// begin passes the queue stage, then the result register, before its result appears
// the whole chain of phase steps for an item runs combinationally in the back end
// loads and unused operations give no result; loads drain even when out stalls
// synchronous active-low reset; no clearing pass, items are taken right away
// a stalled output holds one result while the two-entry queue keeps accepting until full
`default_nettype none

module i2c_master_transfer_sequencer_core
  import i2cseq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic         q_full;
  logic         q_push;
  queue_entry_t q_push_entry;
  logic         q_valid;
  logic         q_pop;
  queue_entry_t q_entry;

  // accept and classify
  i2cseq_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_entry (q_push_entry)
  );

  // decoupling queue
  i2cseq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  // sequencer and result register
  i2cseq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/i2c_master_transfer_sequencer_core_tb.sv]
// self-checking testbench for the i2c master transfer sequencer core
module i2c_master_transfer_sequencer_core_tb
  import i2cseq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1850;

  // bus flag positions in the order of the item fields
  localparam logic [5:0] F_ACK  = 6'b100000;
  localparam logic [5:0] F_NACK = 6'b010000;
  localparam logic [5:0] F_RX   = 6'b001000;
  localparam logic [5:0] F_STOP = 6'b000100;
  localparam logic [5:0] F_ARB  = 6'b000010;
  localparam logic [5:0] F_ERR  = 6'b000001;

  // one line of the directed table: a register setup or an item
  typedef struct packed {
    logic       setup;
    logic [10:0] addr;
    logic [1:0] mode;
    logic       ten;
    logic [4:0] len0;
    logic [4:0] len1;
    in_item_t   item;
    logic       typed;
    out_item_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state and its copy of the registers
  phase_t seq_phase = PH_DONE;
  status_t seq_outcome = ST_BUSY;
  logic [1:0] seq_buf = '0;
  logic [4:0] seq_offset = '0;
  logic [7:0] tx_store [0:STORE_DEPTH-1];
  logic [10:0] reg_addr = '0;
  logic [1:0] reg_mode = MODE_WRITE;
  logic reg_ten = 1'b0;
  logic [4:0] reg_len0 = '0;
  logic [4:0] reg_len1 = '0;

  out_item_t pending_results[$];
  row_t directed_rows[$];
  int mismatches = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int in_calm = 0;
  int out_calm = 0;

  i2c_master_transfer_sequencer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // byte count of a buffer, capped at the buffer size, zero past buffer one
  function automatic logic [4:0] saturated_len(input logic [1:0] b);
    logic [4:0] n;
    n = (b == 2'd0) ? reg_len0 : ((b == 2'd1) ? reg_len1 : 5'd0);
    if (n > 5'(BUFFER_BYTES)) n = 5'(BUFFER_BYTES);
    return n;
  endfunction

  // leading byte of a 10-bit address: 11110, address bits 10:9, write bit
  function automatic logic [7:0] ten_bit_head();
    return {5'b11110, reg_addr[10:9], 1'b0};
  endfunction

  // advance the sequencer by one item; returns 1 when it yields a result
  function automatic logic sequencer_step(input in_item_t it, output out_item_t res);
    logic f_ack, f_nack, f_rx, f_stop, f_arb, f_err;
    logic again, reading, txv, rxw, rxb;
    logic [7:0] txb;
    logic [3:0] cmd, rxo;
    logic [2:0] clr;
    logic [4:0] n;
    int guard;
    res = '0;
    txv = 1'b0; txb = '0; cmd = '0; clr = '0;
    rxw = 1'b0; rxb = 1'b0; rxo = '0;
    {f_ack, f_nack, f_rx, f_stop, f_arb, f_err} = '0;
    case (it.operation)
      OP_LOAD: begin
        tx_store[{it.load_buffer, it.load_offset}] = it.load_value;
        return 1'b0;
      end
      OP_RESERVED: return 1'b0;
      OP_BEGIN: begin
        seq_phase = PH_START_SEND;
        seq_outcome = ST_BUSY;
        seq_buf = '0;
        seq_offset = '0;
      end
      default: begin
        {f_ack, f_nack, f_rx, f_stop, f_arb, f_err} = {it.flag_ack, it.flag_nack,
          it.flag_rx_valid, it.flag_stop_sent, it.flag_arb_lost, it.flag_bus_error};
      end
    endcase
    reading = (reg_mode == MODE_READ) || (reg_mode == MODE_WRITE_READ);

    // chain phase steps until one has to wait for the bus
    again = 1'b1;
    for (guard = 0; again && guard < 16; guard++) begin
      again = 1'b0;
      if (f_arb || f_err) begin
        if (f_arb) seq_outcome = ST_ARB;
        else seq_outcome = ST_BUSERR;
        seq_phase = PH_DONE;
        break;
      end
      case (seq_phase)
        PH_START_SEND: begin
          if (reg_ten) begin
            txb = ten_bit_head();
          end else begin
            txb = reg_addr[7:0] & 8'hfe;
            if (reg_mode == MODE_READ) txb[0] = 1'b1;
          end
          txv = 1'b1;
          cmd |= CMD_START;
          seq_phase = PH_ADDR_WAIT;
        end
        PH_ADDR_WAIT, PH_ADDR2_WAIT, PH_RADDR_WAIT, PH_DATA_WAIT: begin
          if (f_nack) begin
            clr |= CLR_NACK;
            seq_outcome = ST_NACK;
            seq_phase = PH_STOP_WAIT;
            cmd |= CMD_STOP;
          end else if (f_ack) begin
            clr |= CLR_ACK;
            if (seq_phase == PH_ADDR_WAIT) begin
              if (reg_ten) begin
                seq_phase = PH_ADDR2_WAIT;
                txv = 1'b1;
                txb = reg_addr[7:0];
              end else if (reg_mode == MODE_READ) begin
                seq_phase = PH_RX_WAIT;
                if (saturated_len(seq_buf) == 5'd1) cmd |= CMD_NACK;
              end else begin
                seq_phase = PH_DATA_SEND;
                again = 1'b1;
              end
            end else if (seq_phase == PH_ADDR2_WAIT) begin
              if (reg_mode == MODE_READ) seq_phase = PH_RSTART_SEND;
              else seq_phase = PH_DATA_SEND;
              again = 1'b1;
            end else if (seq_phase == PH_RADDR_WAIT && reading) begin
              seq_phase = PH_RX_WAIT;
            end else begin
              seq_phase = PH_DATA_SEND;
              again = 1'b1;
            end
          end
        end
        PH_RSTART_SEND: begin
          txb = reg_ten ? ten_bit_head() : (reg_addr[7:0] & 8'hfe);
          if (reading) txb[0] = 1'b1;
          txv = 1'b1;
          cmd |= CMD_START;
          seq_phase = PH_RADDR_WAIT;
        end
        PH_DATA_SEND: begin
          if (seq_offset >= saturated_len(seq_buf)) begin
            // buffer used up: move on to the next one
            seq_offset = '0;
            seq_buf = seq_buf + 2'd1;
            if (reg_mode == MODE_WRITE_READ) begin
              seq_phase = PH_RSTART_SEND;
              again = 1'b1;
            end else if (reg_mode == MODE_WRITE || seq_buf > 2'd1) begin
              seq_phase = PH_STOP_WAIT;
              cmd |= CMD_STOP;
            end else begin
              again = 1'b1;
            end
          end else begin
            txv = 1'b1;
            txb = tx_store[{seq_buf[0], seq_offset[3:0]}];
            seq_offset = seq_offset + 5'd1;
            seq_phase = PH_DATA_WAIT;
          end
        end
        PH_RX_WAIT: begin
          if (f_rx) begin
            n = saturated_len(seq_buf);
            if (seq_offset < n) begin
              rxw = 1'b1;
              rxb = seq_buf[0];
              rxo = seq_offset[3:0];
              seq_offset = seq_offset + 5'd1;
            end
            if (seq_offset >= n) begin
              if (n == 5'd1) cmd |= CMD_NACK;
              seq_phase = PH_STOP_WAIT;
              cmd |= CMD_STOP;
            end else begin
              cmd |= CMD_ACK;
              if (n > 5'd1 && seq_offset == n - 5'd1) cmd |= CMD_NACK;
            end
          end
        end
        PH_STOP_WAIT: begin
          if (f_stop) begin
            clr |= CLR_STOP;
            seq_phase = PH_DONE;
          end
        end
        default: begin
          // bus event with no transfer running
          seq_outcome = ST_SWFAULT;
          seq_phase = PH_DONE;
        end
      endcase
    end

    if (seq_phase == PH_DONE) begin
      if (seq_outcome == ST_BUSY) seq_outcome = ST_DONE;
      res.status = seq_outcome;
      res.interrupts_off = 1'b1;
    end
    res.tx_valid = txv;
    res.tx_byte = txv ? txb : 8'h00;
    res.command_bits = cmd;
    res.clear_flags = clr;
    res.rx_write = rxw;
    res.rx_buffer = rxw ? rxb : 1'b0;
    res.rx_offset = rxw ? rxo : 4'h0;
    res.rx_data = rxw ? it.received_byte : 8'h00;
    return 1'b1;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] op, input logic [5:0] fl,
                                         input logic [7:0] rx_byte, input logic lbuf,
                                         input logic [3:0] loff, input logic [7:0] lval);
    return in_item_t'({op, fl, rx_byte, lbuf, loff, lval});
  endfunction

  function automatic out_item_t done_result(input status_t st, input logic [2:0] clr);
    out_item_t r;
    r = '0;
    r.status = st;
    r.clear_flags = clr;
    r.interrupts_off = 1'b1;
    return r;
  endfunction

  function automatic row_t setup_row(input logic [10:0] addr, input logic [1:0] mode,
                                     input logic ten, input logic [4:0] l0,
                                     input logic [4:0] l1);
    row_t r;
    r = '0;
    r.setup = 1'b1;
    r.addr = addr; r.mode = mode; r.ten = ten; r.len0 = l0; r.len1 = l1;
    return r;
  endfunction

  function automatic row_t typed_row(input in_item_t it, input logic typed,
                                     input out_item_t want);
    row_t r;
    r = '0;
    r.item = it;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [4:0] pick_len();
    case ($urandom_range(0, 9))
      0: return 5'd16;
      1: return 5'($urandom_range(17, 31));
      2: return 5'($urandom_range(5, 15));
      default: return 5'($urandom_range(0, 4));
    endcase
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (mismatches < 40) $display("mismatch: %s got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // offer one item, wait for it to be taken, then record what it should yield
  task automatic push_item(input in_item_t it, input logic typed, input out_item_t want);
    int gap;
    logic hit;
    out_item_t res;
    gap = pick_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    hit = 1'b0;
    while (!hit) begin
      @(negedge clk);
      hit = in_ready;
      @(posedge clk);
    end
    if (it.operation != OP_RESERVED) items_sent++;
    if (sequencer_step(it, res)) pending_results.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TARGET_ADDRESS: reg_addr = val[10:0];
      CFG_TRANSFER_MODE:  reg_mode = val[1:0];
      CFG_TEN_BIT:        reg_ten = val[0];
      CFG_FIRST_LENGTH:   reg_len0 = val[4:0];
      CFG_SECOND_LENGTH:  reg_len1 = val[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // reprogram all registers once the block has gone quiet
  task automatic apply_setup(input logic [10:0] addr, input logic [1:0] mode, input logic ten,
                             input logic [4:0] l0, input logic [4:0] l1);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_TARGET_ADDRESS, CFG_DATA_W'(addr));
    write_reg(CFG_TRANSFER_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_TEN_BIT, CFG_DATA_W'(ten));
    write_reg(CFG_FIRST_LENGTH, CFG_DATA_W'(l0));
    write_reg(CFG_SECOND_LENGTH, CFG_DATA_W'(l1));
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, compare each taken item with the oldest expectation
  initial begin
    int gap;
    logic hit;
    out_item_t got, want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = pick_wait(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      hit = 1'b0;
      while (!hit) begin
        @(negedge clk);
        hit = out_valid;
        got = out_data;
        if (hit) begin
          if (pending_results.size() == 0) begin
            report("result with nothing expected", int'(got), 0);
          end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.tx_valid !== want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
            if (got.tx_byte !== want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
            if (got.command_bits !== want.command_bits)
              report("command_bits", got.command_bits, want.command_bits);
            if (got.clear_flags !== want.clear_flags)
              report("clear_flags", got.clear_flags, want.clear_flags);
            if (got.rx_write !== want.rx_write) report("rx_write", got.rx_write, want.rx_write);
            if (got.rx_buffer !== want.rx_buffer)
              report("rx_buffer", got.rx_buffer, want.rx_buffer);
            if (got.rx_offset !== want.rx_offset)
              report("rx_offset", got.rx_offset, want.rx_offset);
            if (got.rx_data !== want.rx_data) report("rx_data", got.rx_data, want.rx_data);
            if (got.interrupts_off !== want.interrupts_off)
              report("interrupts_off", got.interrupts_off, want.interrupts_off);
          end
        end
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int i, steps, pick;
    logic [5:0] fl;

    // directed table
    directed_rows.push_back(typed_row(make_item(OP_EVENT, 6'h00, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b1, done_result(ST_SWFAULT, 3'd0)));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ARB | F_ERR | F_ACK, 8'hff, 1'b1,
                                                4'hf, 8'hff), 1'b1, done_result(ST_ARB, 3'd0)));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ERR, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b1, done_result(ST_BUSERR, 3'd0)));
    directed_rows.push_back(typed_row(make_item(OP_RESERVED, 6'h3f, 8'hff, 1'b1, 4'hf, 8'hff),
                                      1'b0, '0));
    // 7-bit write, first length above the buffer size
    directed_rows.push_back(setup_row(11'h7ff, MODE_WRITE, 1'b0, 5'd31, 5'd0));
    directed_rows.push_back(typed_row(make_item(OP_BEGIN, 6'h3f, 8'h00, 1'b0, 4'h0, 8'h00),
      1'b1, out_item_t'{ST_BUSY, 1'b1, 8'hfe, CMD_START, 3'd0, 1'b0, 1'b0, 4'h0, 8'h00, 1'b0}));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    // nack wins over ack
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK | F_NACK, 8'h00, 1'b0, 4'h0,
      8'h00), 1'b1, out_item_t'{ST_BUSY, 1'b0, 8'h00, CMD_STOP, CLR_NACK, 1'b0, 1'b0, 4'h0,
      8'h00, 1'b0}));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_STOP, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b1, done_result(ST_NACK, CLR_STOP)));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK | F_NACK | F_RX | F_STOP,
      8'hff, 1'b1, 4'hf, 8'hff), 1'b1, done_result(ST_SWFAULT, 3'd0)));
    directed_rows.push_back(typed_row(make_item(OP_LOAD, 6'h00, 8'h00, 1'b1, 4'hf, 8'hff),
                                      1'b0, '0));
    // plain 10-bit read of a single byte
    directed_rows.push_back(setup_row(11'h000, MODE_READ, 1'b1, 5'd1, 5'd16));
    directed_rows.push_back(typed_row(make_item(OP_BEGIN, 6'h00, 8'h00, 1'b0, 4'h0, 8'h00),
      1'b1, out_item_t'{ST_BUSY, 1'b1, 8'hf0, CMD_START, 3'd0, 1'b0, 1'b0, 4'h0, 8'h00, 1'b0}));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_RX, 8'hff, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_STOP, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    // write of an empty buffer, then repeated start and a two-byte read
    directed_rows.push_back(setup_row(11'h0aa, MODE_WRITE_READ, 1'b0, 5'd0, 5'd2));
    directed_rows.push_back(typed_row(make_item(OP_BEGIN, 6'h00, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_RX, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_RX, 8'ha5, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    // two-buffer 10-bit write, restarted part way through
    directed_rows.push_back(setup_row(11'h6ff, MODE_WRITE_TWO, 1'b1, 5'd1, 5'd1));
    directed_rows.push_back(typed_row(make_item(OP_BEGIN, 6'h00, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_BEGIN, 6'h00, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));
    directed_rows.push_back(typed_row(make_item(OP_EVENT, F_ACK, 8'h00, 1'b0, 4'h0, 8'h00),
                                      1'b0, '0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // give every transmit byte a value before any transfer can read it
    for (i = 0; i < STORE_DEPTH; i++)
      push_item(make_item(OP_LOAD, 6'h00, 8'($urandom), 1'(i / BUFFER_BYTES),
                          4'(i % BUFFER_BYTES), 8'($urandom)), 1'b0, '0);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].setup)
        apply_setup(directed_rows[k].addr, directed_rows[k].mode, directed_rows[k].ten,
                    directed_rows[k].len0, directed_rows[k].len1);
      else
        push_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    end

    // random transfers, mostly well formed with some noise mixed in
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 7))
          0: apply_setup(11'h000, 2'($urandom), 1'($urandom), pick_len(), pick_len());
          1: apply_setup(11'h7ff, 2'($urandom), 1'($urandom), pick_len(), pick_len());
          default: apply_setup(11'($urandom), 2'($urandom), 1'($urandom), pick_len(),
                               pick_len());
        endcase
      end
      repeat ($urandom_range(0, 3))
        push_item(make_item(OP_LOAD, 6'($urandom), 8'($urandom), 1'($urandom), 4'($urandom),
                            8'($urandom)), 1'b0, '0);
      push_item(make_item(OP_BEGIN, 6'($urandom), 8'($urandom), 1'($urandom), 4'($urandom),
                          8'($urandom)), 1'b0, '0);
      steps = 0;
      while (seq_phase != PH_DONE && steps < 80) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          case (seq_phase)
            PH_ADDR_WAIT, PH_ADDR2_WAIT, PH_RADDR_WAIT, PH_DATA_WAIT:
              fl = ($urandom_range(0, 15) == 0) ? F_NACK : F_ACK;
            PH_RX_WAIT: fl = F_RX;
            PH_STOP_WAIT: fl = F_STOP;
            default: fl = '0;
          endcase
          push_item(make_item(OP_EVENT, fl, 8'($urandom), 1'($urandom), 4'($urandom),
                              8'($urandom)), 1'b0, '0);
        end else if (pick < 88) begin
          push_item(make_item(OP_LOAD, 6'($urandom), 8'($urandom), 1'($urandom),
                              4'($urandom), 8'($urandom)), 1'b0, '0);
        end else if (pick < 95) begin
          push_item(in_item_t'($urandom), 1'b0, '0);
        end else if (pick < 97) begin
          push_item(make_item(OP_BEGIN, 6'($urandom), 8'($urandom), 1'($urandom),
                              4'($urandom), 8'($urandom)), 1'b0, '0);
        end else begin
          fl = ($urandom_range(0, 1) == 0) ? F_ARB : F_ERR;
          push_item(make_item(OP_EVENT, fl | (6'($urandom) & 6'b111101), 8'($urandom),
                              1'($urandom), 4'($urandom), 8'($urandom)), 1'b0, '0);
        end
        steps++;
      end
      // stray bus event after the transfer has ended or its step limit is reached
      if ($urandom_range(0, 7) == 0)
        push_item(make_item(OP_EVENT, 6'($urandom) & 6'b111100, 8'($urandom), 1'($urandom),
                            4'($urandom), 8'($urandom)), 1'b0, '0);
    end

    // drain and finish
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/i2cseq_pkg.sv
design/i2cseq_front.sv
design/i2cseq_queue.sv
design/i2cseq_back.sv
design/i2c_master_transfer_sequencer_core.sv
tb/i2c_master_transfer_sequencer_core_tb.sv
